// ===== rtl/core/dcp_pkg.sv =====
// Package for the distance constraint projection core.
// Holds coordinate constants and register indexes; no dependencies.
package dcp_pkg;
    localparam int COORD_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int REST_WIDTH        = 31;
    localparam int REST_RESET        = 65536;

    typedef enum logic {
        t_REG_REST_LENGTH = 1'b0,
        t_REG_MOVE_FIRST  = 1'b1
    } t_reg_index;
endpackage

// ===== rtl/core/distance_constraint_projection_core.sv =====
// Distance constraint projection core: top level with the full datapath.
// Depends on dcp_pkg for register indexes and default widths.
//
// Usage: the slave stream carries two 3-D body positions per transaction
// (first x,y,z then second x,y,z, signed fixed point). The master stream
// returns the corrected position of the moving body plus a coincident flag
// in tuser. Register 0 sets the rest length, register 1 picks which body moves.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data.
// Pipeline: three front stages, one square root stage per root bit, one
// multiply stage, one divide stage per quotient bit and the output register.
// Since every stage holds a transaction of its own, one transaction is
// accepted every cycle while the output register is free.
// Throughput: one transaction per cycle while the master side accepts.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls, the whole pipeline holds; s_axis_tready drops only
// while the output register holds a result that is not taken.
// The coincident flag is set when both positions are equal; the moving body
// position then passes through unchanged. Results saturate to the coordinate
// range.
module distance_constraint_projection_core
    import dcp_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // moved_x, moved_y, moved_z
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // coincident
    output logic m_axis_tuser,
    input  logic i_cfg_we,
    input  logic i_cfg_index,
    input  logic [REST_WIDTH-1:0] i_cfg_data
);
    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;              // difference magnitude width
    localparam int SW  = 2*DW + 2;            // sum of squares width
    localparam int LW  = DW + 1;              // root width
    localparam int NW  = DW + REST_WIDTH;     // numerator width
    localparam int QW  = REST_WIDTH + 1;      // quotient width (q <= rest)
    localparam int SQN = LW;                  // root stages
    localparam int DVN = QW;                  // divide stages
    localparam int OPAD = ((3*CW+7)/8)*8 - 3*CW;
    localparam logic signed [CW+1:0] CMAX = (CW+2)'((64'sd1 <<< (CW-1)) - 1);
    localparam logic signed [CW+1:0] CMIN = -CMAX - (CW+2)'(1);

    // FRACTION_BITS cancels in the arithmetic; it only documents the format.
    localparam int UNUSED_FB = FRACTION_BITS;

    // Configuration registers.
    logic [REST_WIDTH-1:0] r_rest;
    logic                  r_move_first;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest       <= REST_WIDTH'(REST_RESET);
            r_move_first <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                t_REG_REST_LENGTH: r_rest       <= i_cfg_data;
                t_REG_MOVE_FIRST:  r_move_first <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Global stall: pipeline advances when the output register is free.
    logic w_adv;
    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // Stage A: select mover/anchor, form differences.
    logic                       r_va;
    logic signed [CW-1:0]       r_a_mv [3];
    logic signed [CW-1:0]       r_a_an [3];
    logic        [DW-1:0]       r_a_mag [3];
    logic                       r_a_neg [3];
    logic [REST_WIDTH-1:0]      r_a_rest;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_va <= 1'b0;
        else if (w_adv) r_va <= s_axis_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [CW-1:0] f, s, m, a;
                logic signed [DW-1:0] d;
                f = s_axis_tdata[i*CW +: CW];
                s = s_axis_tdata[(i+3)*CW +: CW];
                m = r_move_first ? f : s;
                a = r_move_first ? s : f;
                d = DW'(m) - DW'(a);
                r_a_mv[i]  <= m;
                r_a_an[i]  <= a;
                r_a_neg[i] <= d[DW-1];
                r_a_mag[i] <= d[DW-1] ? DW'(-d) : DW'(d);
            end
            r_a_rest <= r_rest;
        end
    end

    // Stage B: squares (one multiplier per lane, registered).
    logic                   r_vb;
    logic [2*DW-1:0]        r_b_sq [3];
    logic signed [CW-1:0]   r_b_mv [3];
    logic signed [CW-1:0]   r_b_an [3];
    logic [DW-1:0]          r_b_mag [3];
    logic                   r_b_neg [3];
    logic [REST_WIDTH-1:0]  r_b_rest;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vb <= 1'b0;
        else if (w_adv) r_vb <= r_va;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_b_sq[i]  <= r_a_mag[i] * r_a_mag[i];
                r_b_mv[i]  <= r_a_mv[i];
                r_b_an[i]  <= r_a_an[i];
                r_b_mag[i] <= r_a_mag[i];
                r_b_neg[i] <= r_a_neg[i];
            end
            r_b_rest <= r_a_rest;
        end
    end

    // Stage C: sum of squares.
    logic                   r_vc;
    logic [SW-1:0]          r_c_sum;
    logic signed [CW-1:0]   r_c_mv [3];
    logic signed [CW-1:0]   r_c_an [3];
    logic [DW-1:0]          r_c_mag [3];
    logic                   r_c_neg [3];
    logic [REST_WIDTH-1:0]  r_c_rest;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vc <= 1'b0;
        else if (w_adv) r_vc <= r_vb;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_sum  <= SW'(r_b_sq[0]) + SW'(r_b_sq[1]) + SW'(r_b_sq[2]);
            r_c_mv   <= r_b_mv;
            r_c_an   <= r_b_an;
            r_c_mag  <= r_b_mag;
            r_c_neg  <= r_b_neg;
            r_c_rest <= r_b_rest;
        end
    end

    // Square root pipeline: restoring, one root bit per stage.
    logic                  r_sq_v    [SQN+1];
    logic [SW-1:0]         r_sq_rem  [SQN+1];
    logic [LW-1:0]         r_sq_root [SQN+1];
    logic signed [CW-1:0]  r_sq_mv   [SQN+1][3];
    logic signed [CW-1:0]  r_sq_an   [SQN+1][3];
    logic [DW-1:0]         r_sq_mag  [SQN+1][3];
    logic                  r_sq_neg  [SQN+1][3];
    logic [REST_WIDTH-1:0] r_sq_rest [SQN+1];

    always_comb begin
        r_sq_v[0]    = r_vc;
        r_sq_rem[0]  = r_c_sum;
        r_sq_root[0] = '0;
        r_sq_mv[0]   = r_c_mv;
        r_sq_an[0]   = r_c_an;
        r_sq_mag[0]  = r_c_mag;
        r_sq_neg[0]  = r_c_neg;
        r_sq_rest[0] = r_c_rest;
    end

    for (genvar k = 0; k < SQN; k++) begin : g_sqrt
        localparam int B = SQN - 1 - k;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_v[k+1] <= 1'b0;
            else if (w_adv) r_sq_v[k+1] <= r_sq_v[k];
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                logic [SW+1:0] t;
                // (2r + 2^b) * 2^b = trial increase of r^2.
                t = ((SW+2)'(r_sq_root[k]) << (B+1)) + ((SW+2)'(1) << (2*B));
                if (t <= (SW+2)'(r_sq_rem[k])) begin
                    r_sq_rem[k+1]  <= SW'((SW+2)'(r_sq_rem[k]) - t);
                    r_sq_root[k+1] <= r_sq_root[k] | (LW'(1) << B);
                end else begin
                    r_sq_rem[k+1]  <= r_sq_rem[k];
                    r_sq_root[k+1] <= r_sq_root[k];
                end
                r_sq_mv[k+1]   <= r_sq_mv[k];
                r_sq_an[k+1]   <= r_sq_an[k];
                r_sq_mag[k+1]  <= r_sq_mag[k];
                r_sq_neg[k+1]  <= r_sq_neg[k];
                r_sq_rest[k+1] <= r_sq_rest[k];
            end
        end
    end

    // Stage D: numerators |d| * rest, one multiplier per lane.
    logic                  r_vd;
    logic [NW-1:0]         r_d_num [3];
    logic [LW-1:0]         r_d_len;
    logic signed [CW-1:0]  r_d_mv [3];
    logic signed [CW-1:0]  r_d_an [3];
    logic                  r_d_neg [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vd <= 1'b0;
        else if (w_adv) r_vd <= r_sq_v[SQN];
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++)
                r_d_num[i] <= NW'(r_sq_mag[SQN][i]) * NW'(r_sq_rest[SQN]);
            r_d_len <= r_sq_root[SQN];
            r_d_mv  <= r_sq_mv[SQN];
            r_d_an  <= r_sq_an[SQN];
            r_d_neg <= r_sq_neg[SQN];
        end
    end

    // Divide pipeline: restoring, one quotient bit per stage for each lane.
    logic                  r_dv_v   [DVN+1];
    logic [NW-1:0]         r_dv_rem [DVN+1][3];
    logic [QW-1:0]         r_dv_q   [DVN+1][3];
    logic [LW-1:0]         r_dv_len [DVN+1];
    logic signed [CW-1:0]  r_dv_mv  [DVN+1][3];
    logic signed [CW-1:0]  r_dv_an  [DVN+1][3];
    logic                  r_dv_neg [DVN+1][3];

    always_comb begin
        r_dv_v[0]   = r_vd;
        r_dv_rem[0] = r_d_num;
        r_dv_len[0] = r_d_len;
        r_dv_mv[0]  = r_d_mv;
        r_dv_an[0]  = r_d_an;
        r_dv_neg[0] = r_d_neg;
        for (int i = 0; i < 3; i++) r_dv_q[0][i] = '0;
    end

    for (genvar k = 0; k < DVN; k++) begin : g_div
        localparam int B = DVN - 1 - k;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv_v[k+1] <= 1'b0;
            else if (w_adv) r_dv_v[k+1] <= r_dv_v[k];
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                for (int i = 0; i < 3; i++) begin
                    logic [NW+QW-1:0] t;
                    t = (NW+QW)'(r_dv_len[k]) << B;
                    if (r_dv_len[k] != '0 && t <= (NW+QW)'(r_dv_rem[k][i])) begin
                        r_dv_rem[k+1][i] <= NW'((NW+QW)'(r_dv_rem[k][i]) - t);
                        r_dv_q[k+1][i]   <= r_dv_q[k][i] | (QW'(1) << B);
                    end else begin
                        r_dv_rem[k+1][i] <= r_dv_rem[k][i];
                        r_dv_q[k+1][i]   <= r_dv_q[k][i];
                    end
                end
                r_dv_len[k+1] <= r_dv_len[k];
                r_dv_mv[k+1]  <= r_dv_mv[k];
                r_dv_an[k+1]  <= r_dv_an[k];
                r_dv_neg[k+1] <= r_dv_neg[k];
            end
        end
    end

    // Output register: apply offset, saturate, or pass through on coincidence.
    logic [3*CW-1:0] r_out;
    logic            r_coinc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tvalid <= 1'b0;
        else if (w_adv) m_axis_tvalid <= r_dv_v[DVN];
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [CW+1:0] r;
                logic signed [CW+1:0] q;
                q = (CW+2)'($signed({1'b0, r_dv_q[DVN][i]}));
                r = (CW+2)'(r_dv_an[DVN][i]) + (r_dv_neg[DVN][i] ? -q : q);
                if (r_dv_len[DVN] == '0)
                    r_out[i*CW +: CW] <= r_dv_mv[DVN][i];
                else if (r > CMAX)
                    r_out[i*CW +: CW] <= CMAX[CW-1:0];
                else if (r < CMIN)
                    r_out[i*CW +: CW] <= CMIN[CW-1:0];
                else
                    r_out[i*CW +: CW] <= r[CW-1:0];
            end
            r_coinc <= (r_dv_len[DVN] == '0);
        end
    end

    if (OPAD > 0) begin : g_pad
        assign m_axis_tdata = {OPAD'(UNUSED_FB * 0), r_out};
    end else begin : g_nopad
        assign m_axis_tdata = r_out;
    end
    assign m_axis_tuser = r_coinc;

    // Checks on the pipeline control.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("ready low with empty output register");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_coinc_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_v[DVN] && w_adv && r_dv_len[DVN] == '0 |=> m_axis_tuser)
        else $error("coincident flag lost");
endmodule

// ===== sim/tb_distance_constraint_projection_core.sv =====
// Testbench for the distance constraint projection core.
// Depends on dcp_pkg and distance_constraint_projection_core; self-checking.
`timescale 1ns / 1ps

module tb_distance_constraint_projection_core;
    import dcp_pkg::*;

    localparam int CW       = COORD_WIDTH_DEF;
    localparam int IN_W     = ((6*CW+7)/8)*8;
    localparam int OUT_W    = ((3*CW+7)/8)*8;
    localparam int LATENCY  = 3 + (CW+2) + 1 + (REST_WIDTH+1) + 1;
    localparam int WDOG_MAX = 20000;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          coincident;
    } t_position;

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // first_x, first_y, first_z, second_x, second_y, second_z
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // moved_x, moved_y, moved_z
    logic [OUT_W-1:0] m_axis_tdata;
    // coincident
    logic m_axis_tuser;
    logic i_cfg_we;
    t_reg_index i_cfg_index;
    logic [REST_WIDTH-1:0] i_cfg_data;

    // Predictor copy of the registers.
    logic [REST_WIDTH-1:0] rest_len_q;
    logic                  move_first_q;

    t_position expected_positions[$];
    int  mismatches;
    int  results_seen;
    int  coincident_seen;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  idle_cycles;

    distance_constraint_projection_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Exact integer square root, floor.
    function automatic logic [63:0] floor_sqrt(input logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= s) r = c;
        end
        return r;
    endfunction

    // Corrected position of the moving body for one pair of positions.
    function automatic t_position project_position(input logic [IN_W-1:0] pair);
        t_position        res;
        logic signed [63:0] mv[3];
        logic signed [63:0] an[3];
        logic signed [63:0] d;
        logic signed [63:0] r;
        logic [63:0]      mag[3];
        logic [127:0]     sum;
        logic [63:0]      len;
        logic [127:0]     q;
        logic             neg[3];
        logic signed [63:0] cmax;
        logic signed [63:0] cmin;
        logic [CW-1:0]    outv[3];
        cmax = (64'sd1 <<< (CW-1)) - 1;
        cmin = -cmax - 1;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            mv[i] = move_first_q ? 64'(signed'(pair[i*CW +: CW]))
                                 : 64'(signed'(pair[(i+3)*CW +: CW]));
            an[i] = move_first_q ? 64'(signed'(pair[(i+3)*CW +: CW]))
                                 : 64'(signed'(pair[i*CW +: CW]));
            d = mv[i] - an[i];
            neg[i] = d < 0;
            mag[i] = neg[i] ? -d : d;
            sum += {64'd0, mag[i]} * {64'd0, mag[i]};
        end
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            if (len == 0) begin
                outv[i] = mv[i][CW-1:0];
            end else begin
                q = ({64'd0, mag[i]} * {97'd0, rest_len_q}) / {64'd0, len};
                r = an[i] + (neg[i] ? -signed'(q[63:0]) : signed'(q[63:0]));
                if (r > cmax) r = cmax;
                if (r < cmin) r = cmin;
                outv[i] = r[CW-1:0];
            end
        end
        res.x = outv[0];
        res.y = outv[1];
        res.z = outv[2];
        res.coincident = (len == 0);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                   input logic [CW-1:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    // Result checker and receiver-side stalls.
    always @(posedge i_clk) begin
        t_position want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_positions.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[0 +: CW], '0);
            end else begin
                want = expected_positions.pop_front();
                if (m_axis_tuser) coincident_seen++;
                if (m_axis_tdata[0 +: CW] !== want.x)
                    report_mismatch("moved_x", m_axis_tdata[0 +: CW], want.x);
                if (m_axis_tdata[CW +: CW] !== want.y)
                    report_mismatch("moved_y", m_axis_tdata[CW +: CW], want.y);
                if (m_axis_tdata[2*CW +: CW] !== want.z)
                    report_mismatch("moved_z", m_axis_tdata[2*CW +: CW], want.z);
                if (m_axis_tuser !== want.coincident)
                    report_mismatch("coincident", m_axis_tuser, want.coincident);
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Valid stays high between back-to-back transactions; it drops only on idles.
    task automatic send_pair(input logic [IN_W-1:0] pair);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pair;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_positions.push_back(project_position(pair));
        @(negedge i_clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_positions.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_register(input t_reg_index idx, input logic [REST_WIDTH-1:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == t_REG_REST_LENGTH) rest_len_q = val;
        else move_first_q = val[0];
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return {1'b0, {(CW-1){1'b1}}};
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return CW'($urandom_range(2000)) - CW'(1000);
            3: return CW'($urandom_range(20000000)) - CW'(10000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IN_W-1:0] make_pair(input logic [CW-1:0] c[6]);
        logic [IN_W-1:0] p;
        p = '0;
        for (int i = 0; i < 6; i++) p[i*CW +: CW] = c[i];
        return p;
    endfunction

    task automatic test_directed;
        logic [CW-1:0] c[6];
        logic [CW-1:0] maxv;
        logic [CW-1:0] minv;
        maxv = {1'b0, {(CW-1){1'b1}}};
        minv = {1'b1, {(CW-1){1'b0}}};
        for (int m = 0; m < 2; m++) begin
            write_register(t_REG_MOVE_FIRST, REST_WIDTH'(m));
            // Coincident positions, zeros and extremes.
            c = '{0, 0, 0, 0, 0, 0};                        send_pair(make_pair(c));
            c = '{maxv, minv, 5, maxv, minv, 5};            send_pair(make_pair(c));
            // Opposite extremes: the largest differences.
            c = '{maxv, maxv, maxv, minv, minv, minv};      send_pair(make_pair(c));
            c = '{minv, minv, minv, maxv, maxv, maxv};      send_pair(make_pair(c));
            // Along one axis, and unit offsets.
            c = '{32'h30000, 0, 0, 0, 0, 0};                send_pair(make_pair(c));
            c = '{1, 1, 1, 0, 0, 0};                        send_pair(make_pair(c));
            c = '{-1, 0, 0, 0, 0, 0};                       send_pair(make_pair(c));
            c = '{32'hffff, 32'h1, 32'hfffffffe, 0, 7, 9};  send_pair(make_pair(c));
        end
        write_register(t_REG_REST_LENGTH, '1);
        c = '{maxv, 0, 0, minv, 0, 0};                      send_pair(make_pair(c));
        c = '{minv, 3, 0, 0, 0, 0};                         send_pair(make_pair(c));
        write_register(t_REG_REST_LENGTH, '0);
        c = '{100, 200, 300, 1, 2, 3};                      send_pair(make_pair(c));
        write_register(t_REG_MOVE_FIRST, REST_WIDTH'(1));
        c = '{100, 200, 300, 1, 2, 3};                      send_pair(make_pair(c));
    endtask

    // Random pairs under one register setting.
    task automatic test_random(input int count, input logic [REST_WIDTH-1:0] rest,
                               input logic move_first);
        logic [CW-1:0] c[6];
        write_register(t_REG_REST_LENGTH, rest);
        write_register(t_REG_MOVE_FIRST, REST_WIDTH'(move_first));
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 6; i++) c[i] = rand_coord();
            // Some pairs share coordinates, a few coincide entirely.
            if ($urandom_range(9) == 0) for (int i = 0; i < 3; i++) c[i+3] = c[i];
            else if ($urandom_range(4) == 0) c[3] = c[0];
            send_pair(make_pair(c));
        end
    endtask

    task automatic run_random_phase;
        test_random(150, REST_WIDTH'(REST_RESET), 1'b1);
        test_random(150, REST_WIDTH'($urandom), 1'b0);
        test_random(100, '1, 1'b1);
        test_random(100, '0, 1'b0);
        test_random(80, REST_WIDTH'($urandom_range(65536)), 1'b1);
    endtask

    initial begin
        mismatches      = 0;
        results_seen    = 0;
        coincident_seen = 0;
        idle_cycles     = 0;
        send_idle_pct   = 11;
        recv_idle_pct   = 51;
        rest_len_q      = REST_WIDTH'(REST_RESET);
        move_first_q    = 1'b1;
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        m_axis_tready   = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = t_REG_REST_LENGTH;
        i_cfg_data      = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        run_random_phase();
        send_idle_pct = 51;
        recv_idle_pct = 11;
        run_random_phase();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase();
        drain();

        $display("Covered %0d results (%0d coincident) over both moving-body modes,",
                 results_seen, coincident_seen);
        $display("rest lengths from zero to full scale, under three stall patterns.");
        if (mismatches == 0 && expected_positions.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
